// ===== hdl/stxfr_pkg.sv =====
// Shared types and constants for the STX / length / XOR frame receiver.
// No dependencies; used by stxfr_core and stx_length_xor_frame_receiver.
package stxfr_pkg;

  localparam logic [7:0] STX_BYTE = 8'h02;

  // Result codes
  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BADSUM  = 3'd2,
    KIND_HDR_ERR = 3'd3,
    KIND_LEN_ERR = 3'd4
  } kind_t;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_START   = 4'b0001,
    PH_LEN     = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CHECK   = 4'b1000
  } phase_t;

  // Register indexes on the write port
  typedef enum logic {
    REG_MAX_LEN  = 1'b0,
    REG_CHECK_EN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] max_payload_len;
    logic        check_enable;
  } cfg_t;

  typedef struct packed {
    logic        hit;           // this byte produces a result beat
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
  } res_t;

  // Length reported on the 16-bit field, saturated
  function automatic logic [15:0] sat16(input logic [31:0] v);
    logic [15:0] r;
    r = (|v[31:16]) ? 16'hFFFF : v[15:0];
    return r;
  endfunction

endpackage

// ===== hdl/stxfr_core.sv =====
// Frame parser state machine: start search, length, payload, checksum.
// Computes the result for the byte at its input; state moves on step.
// Depends on stxfr_pkg.
module stxfr_core #(
  parameter int LEN_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  stxfr_pkg::cfg_t   cfg,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output stxfr_pkg::res_t   res
);
  import stxfr_pkg::*;

  localparam logic [32:0] LenLimit = (33'd1 << LEN_BITS) - 33'd1;

  phase_t              phase, phase_next;
  logic [1:0]          hdr_cnt, hdr_cnt_next;
  logic [31:0]         length_word, length_word_next;
  logic [LEN_BITS-1:0] bytes_left, bytes_left_next;
  logic [7:0]          running_xor, running_xor_next;

  logic [31:0]         len_cat;
  logic                too_long;
  logic [LEN_BITS-1:0] left_dec;

  assign len_cat  = {length_word[23:0], rx_byte};
  assign too_long = (len_cat > {16'd0, cfg.max_payload_len}) ||
                    ({1'b0, len_cat} > LenLimit);
  assign left_dec = (bytes_left != '0) ? bytes_left - LEN_BITS'(1) : bytes_left;

  always_comb begin
    phase_next       = phase;
    hdr_cnt_next     = hdr_cnt;
    length_word_next = length_word;
    bytes_left_next  = bytes_left;
    running_xor_next = running_xor;
    res.hit          = 1'b0;
    res.kind         = KIND_DATA;
    res.data_byte    = rx_byte;
    res.frame_length = sat16(length_word);
    case (phase)
      PH_START: begin
        if (rx_byte != STX_BYTE) begin
          hdr_cnt_next     = 2'd0;
          res.hit          = 1'b1;
          res.kind         = KIND_HDR_ERR;
          res.frame_length = 16'd0;
        end else if (hdr_cnt == 2'd3) begin
          hdr_cnt_next     = 2'd0;
          length_word_next = 32'd0;
          phase_next       = PH_LEN;
        end else begin
          hdr_cnt_next = hdr_cnt + 2'd1;
        end
      end
      PH_LEN: begin
        length_word_next = len_cat;
        if (hdr_cnt != 2'd3) begin
          hdr_cnt_next = hdr_cnt + 2'd1;
        end else begin
          hdr_cnt_next     = 2'd0;
          running_xor_next = 8'd0;
          if (too_long) begin
            phase_next       = PH_START;
            bytes_left_next  = '0;
            res.hit          = 1'b1;
            res.kind         = KIND_LEN_ERR;
            res.frame_length = sat16(len_cat);
          end else begin
            bytes_left_next = len_cat[LEN_BITS-1:0];
            // zero-length frame goes straight to the checksum byte
            phase_next = (len_cat[LEN_BITS-1:0] == '0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        running_xor_next = running_xor ^ rx_byte;
        bytes_left_next  = left_dec;
        if (left_dec == '0) begin
          phase_next = PH_CHECK;
        end
        res.hit  = 1'b1;
        res.kind = KIND_DATA;
      end
      PH_CHECK: begin
        phase_next   = PH_START;
        hdr_cnt_next = 2'd0;
        res.hit      = 1'b1;
        res.kind     = (!cfg.check_enable || rx_byte == running_xor) ? KIND_GOOD
                                                                      : KIND_BADSUM;
      end
      default: begin
        phase_next   = PH_START;
        hdr_cnt_next = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      hdr_cnt     <= 2'd0;
      length_word <= 32'd0;
      bytes_left  <= '0;
      running_xor <= 8'd0;
    end else if (step) begin
      phase       <= phase_next;
      hdr_cnt     <= hdr_cnt_next;
      length_word <= length_word_next;
      bytes_left  <= bytes_left_next;
      running_xor <= running_xor_next;
    end
  end

  // payload phase always has bytes still to come
  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_left != '0)
    else $error("payload phase with no bytes left");

  // byte count only runs in start and length phases
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD || phase == PH_CHECK) |-> hdr_cnt == 2'd0)
    else $error("header count not cleared");

endmodule

// ===== hdl/stx_length_xor_frame_receiver.sv =====
// STX / length / XOR-checksum frame receiver, top level.
// Input byte register, output result register, config registers.
// Depends on stxfr_pkg and stxfr_core.
//
// Usage:
//   Bytes enter on in_valid/in_ready/rx_byte, one beat per byte. Frames are
//   four 0x02 start bytes, a 32-bit big-endian length, the payload and an
//   XOR checksum byte. Each payload byte leaves as a kind DATA beat on
//   out_valid/out_ready; the checksum byte gives GOOD or BADSUM. A wrong
//   start byte gives HDR_ERR, an oversized length LEN_ERR. Start and length
//   bytes other than those produce no output beat.
//   Throughput is one byte per cycle unless the output stalls: the byte
//   register and the result register each hold one beat, the parser result
//   is combinational, and out_valid rises as that result is registered.
//   If out_ready stays low, one result waits in the output register and one
//   byte in the input register; in_ready drops only then. Bytes that make
//   no result pass even while the output is stalled.
//   Reset clears the parser to start search and sets max_payload_len to
//   256 and check_enable to 1. Config writes via cfg_we are registered.
module stx_length_xor_frame_receiver #(
  parameter int LEN_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output stxfr_pkg::kind_t   kind,
  output logic [7:0]         data_byte,
  output logic [15:0]        frame_length
);
  import stxfr_pkg::*;

  cfg_t       cfg;
  logic       in_vld;
  logic [7:0] in_byte;
  res_t       res;
  logic       out_free;
  logic       advance;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload_len <= 16'd256;
      cfg.check_enable    <= 1'b1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_MAX_LEN:  cfg.max_payload_len <= cfg_wdata;
        REG_CHECK_EN: cfg.check_enable    <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;
  assign advance  = in_vld && (!res.hit || out_free);
  assign in_ready = !in_vld || advance;

  // input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte <= rx_byte;
    end
  end

  stxfr_core #(
    .LEN_BITS(LEN_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (advance),
    .rx_byte (in_byte),
    .res     (res)
  );

  // output result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.hit) begin
      kind         <= res.kind;
      data_byte    <= res.data_byte;
      frame_length <= res.frame_length;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_vld && out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    advance && res.hit |=> out_valid)
    else $error("result beat lost");

  a_data_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |-> frame_length != 16'd0)
    else $error("payload beat from zero-length frame");

endmodule

// ===== bench/tb_stx_length_xor_frame_receiver.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stx_length_xor_frame_receiver: random valid/ready traffic,
// a frame parser model that predicts every result beat, and config phases.
// Depends on stxfr_pkg and the receiver RTL.
module tb_stx_length_xor_frame_receiver;
  import stxfr_pkg::*;

  localparam int LEN_BITS = 16;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
  } frame_res_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  kind_t       kind;
  logic [7:0]  data_byte;
  logic [15:0] frame_length;

  stx_length_xor_frame_receiver #(.LEN_BITS(LEN_BITS)) DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .data_byte(data_byte), .frame_length(frame_length)
  );

  // Config mirror and parser state of the model
  logic [15:0]         max_len_reg = 16'd256;
  logic                check_on = 1'b1;
  phase_t              parse_phase = PH_START;
  int                  hdr_seen = 0;
  logic [31:0]         len_acc = '0;
  logic [LEN_BITS-1:0] payload_left = '0;
  logic [7:0]          sum_acc = '0;

  logic [7:0] tx_bytes[$];
  frame_res_t due_results[$];
  int n_queued = 0;
  int n_bytes_in = 0;
  int errors = 0;
  int kind_seen[5] = '{default: 0};
  int in_idle_pct = 12;
  int out_idle_pct = 12;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  frame_res_t want, got;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] clip16(input logic [31:0] v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // Advance the frame parser by one byte; queue the beat it should produce
  task automatic parse_byte(input logic [7:0] b);
    frame_res_t r;
    bit hit;
    hit = 1'b0;
    r.kind = KIND_DATA;
    r.data_byte = b;
    r.frame_length = clip16(len_acc);
    case (parse_phase)
      PH_START: begin
        if (b != STX_BYTE) begin
          hdr_seen = 0;
          hit = 1'b1;
          r.kind = KIND_HDR_ERR;
          r.frame_length = '0;
        end else begin
          hdr_seen++;
          if (hdr_seen == 4) begin
            hdr_seen = 0;
            len_acc = '0;
            parse_phase = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        len_acc = {len_acc[23:0], b};
        hdr_seen++;
        if (hdr_seen == 4) begin
          hdr_seen = 0;
          sum_acc = '0;
          if (len_acc > max_len_reg || {32'b0, len_acc} > (64'd1 << LEN_BITS) - 1) begin
            parse_phase = PH_START;
            payload_left = '0;
            hit = 1'b1;
            r.kind = KIND_LEN_ERR;
            r.frame_length = clip16(len_acc);
          end else begin
            payload_left = len_acc[LEN_BITS-1:0];
            parse_phase = (payload_left == 0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        sum_acc ^= b;
        if (payload_left != 0) payload_left--;
        if (payload_left == 0) parse_phase = PH_CHECK;
        hit = 1'b1;
      end
      default: begin
        hit = 1'b1;
        r.kind = (!check_on || b == sum_acc) ? KIND_GOOD : KIND_BADSUM;
        parse_phase = PH_START;
        hdr_seen = 0;
      end
    endcase
    if (hit) due_results.insert(due_results.size(), r);
  endtask

  // Sender: valid held with stable byte until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(rx_byte);
        n_bytes_in++;
      end
      if (!in_valid || in_ready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat, random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind = kind;
        got.data_byte = data_byte;
        got.frame_length = frame_length;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat kind=%0d data=%02h len=%0d",
                   $time, got.kind, got.data_byte, got.frame_length);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected kind=%0d data=%02h len=%0d, got kind=%0d data=%02h len=%0d",
                     $time, want.kind, want.data_byte, want.frame_length,
                     got.kind, got.data_byte, got.frame_length);
          end
          if (got.kind <= KIND_LEN_ERR) kind_seen[got.kind]++;
        end
      end
      if (hold_arm && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic put(input logic [7:0] b);
    tx_bytes.insert(tx_bytes.size(), b);
    n_queued++;
  endtask

  // Start bytes, big-endian length, and payload plus checksum when the length is legal
  task automatic queue_frame(input logic [31:0] len_word, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    repeat (4) put(STX_BYTE);
    for (int i = 3; i >= 0; i--) put(len_word[8*i +: 8]);
    if (len_word <= max_len_reg) begin
      for (int i = 0; i < len_word; i++) begin
        b = 8'($urandom_range(255));
        sum ^= b;
        put(b);
      end
      if (corrupt) sum ^= 8'h01 << $urandom_range(7);
      put(sum);
    end
  endtask

  // Mostly well-formed frames; the rest oversized lengths and broken start runs
  task automatic queue_mix(input int n);
    int stop_at;
    int pick;
    int cap;
    logic [31:0] len;
    logic [7:0] b;
    stop_at = n_queued + n;
    while (n_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 67) begin
        cap = (max_len_reg < 24) ? max_len_reg : 24;
        queue_frame($urandom_range(cap), $urandom_range(99) < 20);
      end else if (pick < 70) begin
        cap = (max_len_reg < 64) ? max_len_reg : 64;
        queue_frame($urandom_range(cap), $urandom_range(99) < 20);
      end else if (pick < 82) begin
        if ($urandom_range(1) == 0 && max_len_reg != 16'hFFFF)
          len = 32'(max_len_reg) + 1 + $urandom_range(40);
        else
          len = {16'($urandom_range(65535, 1)), 16'($urandom_range(65535))};
        queue_frame(len, 1'b0);
      end else begin
        repeat ($urandom_range(3)) put(STX_BYTE);
        b = 8'($urandom_range(255));
        if (b == STX_BYTE) b = 8'h03;
        put(b);
      end
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_LEN) max_len_reg = val;
    else check_on = val[0];
  endtask

  // Wait for every byte taken and every beat checked, then let the pipe empty
  task automatic settle();
    while (tx_bytes.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults: junk bytes, short start run, empty frame, bad checksum
    put(8'h00);
    put(8'hFF);
    repeat (3) put(STX_BYTE);
    put(8'h55);
    queue_frame(32'd0, 1'b0);
    queue_frame(32'd1, 1'b1);
    settle();

    write_reg(REG_MAX_LEN, 16'd10);
    write_reg(REG_CHECK_EN, 16'd1);
    @(negedge clk);
    hold_arm = 1'b1;
    queue_frame(32'd10, 1'b0);
    queue_frame(32'd11, 1'b0);
    queue_frame(32'hFFFF_FFFF, 1'b0);
    queue_mix(150);
    settle();

    write_reg(REG_MAX_LEN, 16'd0);
    write_reg(REG_CHECK_EN, 16'd0);
    @(negedge clk);
    queue_frame(32'd0, 1'b1);
    queue_frame(32'd1, 1'b0);
    queue_mix(50);
    settle();

    // long frame and the counter limit, no idling on either side
    write_reg(REG_MAX_LEN, 16'hFFFF);
    @(negedge clk);
    in_idle_pct = 0;
    out_idle_pct = 0;
    queue_frame(32'd64, 1'b1);
    queue_frame(32'h0001_0000, 1'b0);
    queue_mix(40);
    settle();

    write_reg(REG_MAX_LEN, 16'd40);
    write_reg(REG_CHECK_EN, 16'd1);
    @(negedge clk);
    in_idle_pct = 12;
    out_idle_pct = 12;
    queue_frame(32'd40, 1'b0);
    queue_frame(32'd41, 1'b0);
    queue_mix(110);
    settle();

    $display("Sent %0d bytes over five register settings; checked %0d payload beats,",
             n_bytes_in, kind_seen[KIND_DATA]);
    $display("%0d good frames, %0d checksum errors, %0d header errors, %0d length errors",
             kind_seen[KIND_GOOD], kind_seen[KIND_BADSUM], kind_seen[KIND_HDR_ERR],
             kind_seen[KIND_LEN_ERR]);
    if (errors == 0 && due_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/stxfr_pkg.sv
hdl/stxfr_core.sv
hdl/stx_length_xor_frame_receiver.sv
bench/tb_stx_length_xor_frame_receiver.sv
